/* src/sor_linear_solver_unit_macros.svh */
// ----------------------------------------------------------------------------
// sor_linear_solver_unit_macros
// Assertion macros shared by the solver RTL.
// ----------------------------------------------------------------------------
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef SOR_LINEAR_SOLVER_UNIT_MACROS_SVH
`define SOR_LINEAR_SOLVER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication: whenever cond holds, prop holds too.
`define SOR_ASSERT_IMP(lbl, cond, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error("solver assertion failed");
// Next-cycle implication: whenever cond holds, prop holds in the cycle after.
`define SOR_ASSERT_NEXT(lbl, cond, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error("solver assertion failed");
`else
`define SOR_ASSERT_IMP(lbl, cond, prop)
`define SOR_ASSERT_NEXT(lbl, cond, prop)
`endif

`endif

/* src/sor_pkg.sv */
// ----------------------------------------------------------------------------
// sor_pkg
// Types and constants of the SOR linear solver.
// ----------------------------------------------------------------------------
`default_nettype none

package sor_pkg;

    localparam logic [1:0] ACT_MATRIX = 2'd0;
    localparam logic [1:0] ACT_RHS    = 2'd1;
    localparam logic [1:0] ACT_GUESS  = 2'd2;
    localparam logic [1:0] ACT_START  = 2'd3;

    localparam logic [1:0] ST_CONVERGED = 2'd0;
    localparam logic [1:0] ST_LIMIT     = 2'd1;
    localparam logic [1:0] ST_ZERO_DIAG = 2'd2;

    localparam logic [1:0] CFG_OMEGA     = 2'd0;
    localparam logic [1:0] CFG_TOLERANCE = 2'd1;
    localparam logic [1:0] CFG_MAX_SWEEP = 2'd2;
    localparam logic [1:0] CFG_SIZE      = 2'd3;

    localparam logic [17:0] OMEGA_RESET = 18'd65536;
    localparam logic [15:0] TOL_RESET   = 16'd66;
    localparam logic [15:0] SWEEP_RESET = 16'd5000;
    localparam logic [6:0]  SIZE_RESET  = 7'd64;

    typedef struct packed {
        logic [1:0]         action;
        logic [5:0]         row;
        logic [5:0]         col;
        logic signed [31:0] value;
    } t_in_item;

    typedef struct packed {
        logic [5:0]         index;
        logic signed [31:0] solution;
        logic               last;
        logic [1:0]         status;
        logic [15:0]        sweeps_done;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DOT,
        S_DECIDE,
        S_DIV,
        S_BL1,
        S_BL2,
        S_BL3,
        S_RSQ,
        S_RACC,
        S_TMUL,
        S_TACC,
        S_CMP,
        S_OREAD,
        S_OWAIT,
        S_OSEND
    } t_state;

endpackage

`default_nettype wire

/* src/sor_in_if.sv */
// ----------------------------------------------------------------------------
// sor_in_if
// Valid/ready channel that carries load and start items into the solver.
// ----------------------------------------------------------------------------
`default_nettype none

interface sor_in_if import sor_pkg::*;;
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* src/sor_out_if.sv */
// ----------------------------------------------------------------------------
// sor_out_if
// Valid/ready channel that carries solution entries out of the solver.
// ----------------------------------------------------------------------------
`default_nettype none

interface sor_out_if import sor_pkg::*;;
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* src/sor_ram.sv */
// ----------------------------------------------------------------------------
// sor_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module sor_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* src/sor_div.sv */
// ----------------------------------------------------------------------------
// sor_div
// Signed 64 by 32 bit divider, one quotient bit per cycle, truncating
// toward zero, quotient saturated to 32 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module sor_div import sor_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [63:0] i_num,
    input  wire logic signed [31:0] i_den,
    output logic                    o_done,
    output logic signed [31:0]      o_quot
);

    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [32:0] r_rem;
    logic [63:0] r_q;
    logic [31:0] r_den;
    logic        r_neg;

    logic [32:0] rem_sh;
    logic        take;

    assign rem_sh = {r_rem[31:0], r_q[63]};
    assign take   = rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num[63] ? 64'(-i_num) : 64'(i_num);
            r_den <= i_den[31] ? 32'(-i_den) : 32'(i_den);
            r_neg <= i_num[63] ^ i_den[31];
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= take ? (rem_sh - {1'b0, r_den}) : rem_sh;
            r_q   <= {r_q[62:0], take};
        end
    end

    // Magnitude saturation: a negative result may reach -2^31.
    always_comb begin
        if (r_neg) begin
            o_quot = (r_q > 64'h0000_0000_8000_0000) ? 32'sh8000_0000 : -$signed(r_q[31:0]);
        end else begin
            o_quot = (r_q > 64'h0000_0000_7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(r_q[31:0]);
        end
    end

    assign o_done = r_done;

endmodule

`default_nettype wire

/* src/sor_linear_solver_unit.sv */
// ----------------------------------------------------------------------------
// sor_linear_solver_unit
// Dense SOR solver for A x = b in Q16.16 with a squared-norm residual test.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Transfer moves
//  i_in      in         one load item (matrix, rhs or guess entry) or a start
//  o_out     out        one solution entry with status and sweep count
//  i_cfg_*   in         one register write, no handshake
//
// Load items are accepted while the block is idle; ready stays high between them.
// A start item runs sweeps over the RAM-held matrix. Each sweep computes the
// row dot products (one coefficient RAM read per cycle), runs the serial
// divider and the blend for each row with a nonzero diagonal, then a residual
// pass and the norm test. Each of the n results is read, registered and then
// held on o_out until o_out.ready is high. Reset is synchronous and active low;
// the RAMs hold no reset value and need no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sor_linear_solver_unit_macros.svh"

module sor_linear_solver_unit import sor_pkg::*; #(
    parameter int DIM = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    sor_in_if.sink           i_in,
    sor_out_if.source        o_out,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [17:0] i_cfg_data
);

    localparam int IW  = $clog2(DIM);
    localparam int AW  = $clog2(DIM * DIM);
    // Squared norms: DIM terms of at most 2^62 each.
    localparam int NW  = 64 + $clog2(DIM) + 1;
    localparam int NCH = (NW + 31) / 32;
    localparam int KW  = $clog2(NCH);
    localparam int PW  = NCH * 32 + 32;
    localparam logic signed [63:0] RLIM = 64'sh0000_7FFF_FFFF_FFFF;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sh0000_0000_7FFF_FFFF) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -64'sh0000_0000_8000_0000) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    // Configuration registers.
    logic [17:0] r_omega;
    logic [15:0] r_tol;
    logic [15:0] r_max_sweeps;
    logic [6:0]  r_size;

    // Control state.
    t_state      r_state;
    t_state      n_state;
    logic [IW-1:0] r_i;
    logic [IW-1:0] r_j;
    logic [IW-1:0] r_j1;
    logic [IW-1:0] r_j2;
    logic [IW-1:0] r_nm1;
    logic          r_issue;
    logic          r_v1;
    logic          r_v2;
    logic          r_res;
    logic [15:0]   r_sweeps;
    logic [15:0]   r_limit;
    logic          r_err;
    logic          r_conv;
    logic [KW-1:0] r_k;

    // Datapath registers.
    logic signed [63:0] r_p;
    logic signed [63:0] r_acc;
    logic signed [31:0] r_aii;
    logic signed [31:0] r_xi;
    logic signed [31:0] r_q;
    logic signed [51:0] r_p1;
    logic signed [51:0] r_p2;
    logic [63:0]        r_sqr;
    logic [63:0]        r_sqb;
    logic [NW-1:0]      r_rn;
    logic [NW-1:0]      r_bn;
    logic [31:0]        r_tol2;
    logic [63:0]        r_cp;
    logic [PW-1:0]      r_rhs;
    t_out_item          r_out;

    // RAM ports.
    logic               coef_we;
    logic [AW-1:0]      coef_waddr;
    logic [AW-1:0]      coef_raddr;
    logic signed [31:0] coef_rd;
    logic               rhs_we;
    logic signed [31:0] rhs_rd;
    logic               sol_we;
    logic [IW-1:0]      sol_waddr;
    logic [31:0]        sol_wdata;
    logic [IW-1:0]      sol_raddr;
    logic signed [31:0] sol_rd;

    logic               div_start;
    logic               div_done;
    logic signed [31:0] div_quot;
    logic signed [63:0] div_num;

    logic               in_fire;
    logic               in_range;
    logic               dot_done;
    logic               row_last;
    logic [6:0]         n_clamp;
    logic signed [63:0] num_r;
    logic signed [52:0] blend;
    logic signed [31:0] x_new;
    logic signed [31:0] resid;
    logic [31:0]        abs_r;
    logic [31:0]        abs_b;
    logic [NCH*32-1:0]  bn_pad;
    logic [15:0]        sweeps_inc;
    logic               finish;
    logic               conv_now;

    // Convergence test: |Ax-b|^2 * 2^32 <= tol^2 * |b|^2. The product is
    // complete in S_CMP, so the test is formed combinationally there and
    // held in r_conv for the output phase.
    assign conv_now   = (PW'({r_rn, 32'b0}) <= r_rhs);

    assign in_fire    = i_in.valid && i_in.ready;
    assign in_range   = ({1'b0, i_in.data.row} < 7'(DIM));
    assign dot_done   = !r_issue && !r_v1 && !r_v2;
    assign row_last   = (r_i == r_nm1);
    assign sweeps_inc = r_sweeps + 16'd1;
    assign finish     = conv_now || (sweeps_inc == r_limit);

    always_comb begin
        if (r_size < 7'd2) begin
            n_clamp = 7'd2;
        end else if (r_size > 7'(DIM)) begin
            n_clamp = 7'(DIM);
        end else begin
            n_clamp = r_size;
        end
    end

    // Numerator of the row update, limited to 47 bits and scaled by 2^16.
    always_comb begin
        num_r = 64'(rhs_rd) - r_acc;
        if (num_r > RLIM) begin
            num_r = RLIM;
        end else if (num_r < -RLIM) begin
            num_r = -RLIM;
        end
        div_num = num_r <<< 16;
    end

    assign blend  = 53'(r_p1) + 53'(r_p2);
    assign x_new  = sat32(64'(blend >>> 16));
    assign resid  = sat32(r_acc - 64'(rhs_rd));
    assign abs_r  = resid[31] ? 32'(-resid) : 32'(resid);
    assign abs_b  = rhs_rd[31] ? 32'(-rhs_rd) : 32'(rhs_rd);
    assign bn_pad = (NCH * 32)'(r_bn);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire && i_in.data.action == ACT_START) begin
                    n_state = S_DOT;
                end
            end
            S_DOT: begin
                if (dot_done) begin
                    n_state = r_res ? S_RSQ : S_DECIDE;
                end
            end
            S_DECIDE: n_state = (r_aii == 32'sd0) ? S_DOT : S_DIV;
            S_DIV: begin
                if (div_done) begin
                    n_state = S_BL1;
                end
            end
            S_BL1:  n_state = S_BL2;
            S_BL2:  n_state = S_BL3;
            S_BL3:  n_state = S_DOT;
            S_RSQ:  n_state = S_RACC;
            S_RACC: n_state = row_last ? S_TMUL : S_DOT;
            S_TMUL: n_state = S_TACC;
            S_TACC: n_state = (r_k == '0) ? S_CMP : S_TMUL;
            S_CMP:  n_state = finish ? S_OREAD : S_DOT;
            S_OREAD: n_state = S_OWAIT;
            S_OWAIT: n_state = S_OSEND;
            S_OSEND: begin
                if (o_out.ready) begin
                    n_state = r_out.last ? S_IDLE : S_OREAD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Memory and handshake controls.
    always_comb begin
        i_in.ready = (r_state == S_IDLE);
        coef_we    = in_fire && i_in.data.action == ACT_MATRIX && in_range
                     && ({1'b0, i_in.data.col} < 7'(DIM));
        coef_waddr = AW'(i_in.data.row[IW-1:0]) * AW'(DIM) + AW'(i_in.data.col[IW-1:0]);
        coef_raddr = AW'(r_i) * AW'(DIM) + AW'(r_j);
        rhs_we     = in_fire && i_in.data.action == ACT_RHS && in_range;
        div_start  = (r_state == S_DECIDE) && (r_aii != 32'sd0);
        sol_raddr  = (r_state == S_DOT) ? r_j : r_i;
        if (r_state == S_BL3) begin
            sol_we    = 1'b1;
            sol_waddr = r_i;
            sol_wdata = x_new;
        end else begin
            sol_we    = in_fire && i_in.data.action == ACT_GUESS && in_range;
            sol_waddr = i_in.data.row[IW-1:0];
            sol_wdata = i_in.data.value;
        end
    end

    assign o_out.valid = (r_state == S_OSEND);
    assign o_out.data  = r_out;

    // Configuration writes must arrive only while the solver is idle; the block itself does not enforce this.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_omega      <= OMEGA_RESET;
            r_tol        <= TOL_RESET;
            r_max_sweeps <= SWEEP_RESET;
            r_size       <= SIZE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_OMEGA:     r_omega      <= i_cfg_data;
                CFG_TOLERANCE: r_tol        <= i_cfg_data[15:0];
                CFG_MAX_SWEEP: r_max_sweeps <= i_cfg_data[15:0];
                CFG_SIZE:      r_size       <= i_cfg_data[6:0];
            endcase
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_issue  <= 1'b0;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_res    <= 1'b0;
            r_i      <= '0;
            r_j      <= '0;
            r_sweeps <= '0;
            r_err    <= 1'b0;
            r_k      <= '0;
        end else begin
            r_state <= n_state;
            r_v1    <= (r_state == S_DOT) && r_issue;
            r_v2    <= r_v1;
            if (r_state == S_DOT && r_issue) begin
                if (r_j == r_nm1) begin
                    r_issue <= 1'b0;
                end else begin
                    r_j <= r_j + 1'b1;
                end
            end
            if (r_state != S_DOT && n_state == S_DOT) begin
                r_issue <= 1'b1;
                r_j     <= '0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (n_state == S_DOT) begin
                        r_i      <= '0;
                        r_res    <= 1'b0;
                        r_sweeps <= '0;
                        r_err    <= 1'b0;
                    end
                end
                S_DECIDE, S_BL3: begin
                    if (r_state == S_DECIDE && r_aii == 32'sd0) begin
                        r_err <= 1'b1;
                    end
                    if (n_state == S_DOT) begin
                        if (row_last) begin
                            r_i   <= '0;
                            r_res <= 1'b1;
                        end else begin
                            r_i <= r_i + 1'b1;
                        end
                    end
                end
                S_RACC: begin
                    if (row_last) begin
                        r_k <= KW'(NCH - 1);
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                S_TACC: begin
                    if (r_k != '0) begin
                        r_k <= r_k - 1'b1;
                    end
                end
                S_CMP: begin
                    r_sweeps <= sweeps_inc;
                    r_i      <= '0;
                    r_res    <= 1'b0;
                end
                S_OSEND: begin
                    if (o_out.ready) begin
                        r_i <= r_i + 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && n_state == S_DOT) begin
            r_nm1   <= IW'(n_clamp - 7'd1);
            r_limit <= (r_max_sweeps == 16'd0) ? 16'd1 : r_max_sweeps;
            r_tol2  <= r_tol * r_tol;
        end
        if (r_state != S_DOT && n_state == S_DOT) begin
            r_acc <= '0;
        end
        // Dot-product pipeline: RAM read, product, accumulate.
        r_j1 <= r_j;
        r_j2 <= r_j1;
        if (r_v1) begin
            r_p <= 64'(coef_rd) * 64'(sol_rd);
            if (r_j1 == r_i) begin
                r_aii <= coef_rd;
                r_xi  <= sol_rd;
            end
        end
        if (r_v2 && (r_res || r_j2 != r_i)) begin
            r_acc <= r_acc + (r_p >>> 16);
        end
        if (div_done) begin
            r_q <= div_quot;
        end
        if (r_state == S_BL1) begin
            r_p1 <= $signed({2'b00, r_omega}) * r_q;
        end
        if (r_state == S_BL2) begin
            r_p2 <= (20'sd65536 - $signed({2'b00, r_omega})) * r_xi;
        end
        if ((r_state == S_DECIDE || r_state == S_BL3) && n_state == S_DOT && row_last) begin
            r_rn <= '0;
            r_bn <= '0;
        end
        if (r_state == S_RSQ) begin
            r_sqr <= abs_r * abs_r;
            r_sqb <= abs_b * abs_b;
        end
        if (r_state == S_RACC) begin
            r_rn  <= r_rn + NW'(r_sqr);
            r_bn  <= r_bn + NW'(r_sqb);
            r_rhs <= '0;
        end
        // tol^2 * |b|^2, most significant 32-bit chunk first.
        if (r_state == S_TMUL) begin
            r_cp <= bn_pad[r_k*32 +: 32] * r_tol2;
        end
        if (r_state == S_TACC) begin
            r_rhs <= (r_rhs << 32) + PW'(r_cp);
        end
        if (r_state == S_CMP) begin
            r_conv <= conv_now;
        end
        if (r_state == S_OWAIT) begin
            r_out.index       <= 6'(r_i);
            r_out.solution    <= sol_rd;
            r_out.last        <= row_last;
            r_out.status      <= r_err ? ST_ZERO_DIAG : (r_conv ? ST_CONVERGED : ST_LIMIT);
            r_out.sweeps_done <= r_sweeps;
        end
    end

    sor_ram #(.WIDTH(32), .DEPTH(DIM * DIM)) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (coef_we),
        .i_waddr (coef_waddr),
        .i_wdata (i_in.data.value),
        .i_raddr (coef_raddr),
        .o_rdata (coef_rd)
    );

    sor_ram #(.WIDTH(32), .DEPTH(DIM)) u_rhs_ram (
        .i_clk   (i_clk),
        .i_we    (rhs_we),
        .i_waddr (i_in.data.row[IW-1:0]),
        .i_wdata (i_in.data.value),
        .i_raddr (r_i),
        .o_rdata (rhs_rd)
    );

    sor_ram #(.WIDTH(32), .DEPTH(DIM)) u_sol_ram (
        .i_clk   (i_clk),
        .i_we    (sol_we),
        .i_waddr (sol_waddr),
        .i_wdata (sol_wdata),
        .i_raddr (sol_raddr),
        .o_rdata (sol_rd)
    );

    sor_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (r_aii),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // The solver never takes an item while a result is on offer.
    `SOR_ASSERT_IMP(a_no_overlap, o_out.valid, !i_in.ready)
    // A run reports at least one sweep and never more than its limit.
    `SOR_ASSERT_IMP(a_sweep_bound, o_out.valid, r_sweeps != 16'd0 && r_sweeps <= r_limit)
    // The final transfer of a run returns the block to idle.
    `SOR_ASSERT_NEXT(a_last_idle, o_out.valid && o_out.ready && o_out.data.last,
        r_state == S_IDLE)
    // Convergence is reported only when the norm test passed.
    `SOR_ASSERT_IMP(a_conv_status, o_out.valid && o_out.data.status == ST_CONVERGED,
        r_conv)

endmodule

`default_nettype wire
